### hdl/dpn_pkg.sv
// Package for the DOS path name checker: character codes, limits on the
// name and extension lengths, and the character class functions.
// No dependencies.
`default_nettype none

package dpn_pkg;

  localparam int unsigned NAME_MAX = 8;
  localparam int unsigned EXT_MAX  = 3;
  localparam int unsigned CNT_W    = 4;

  localparam logic [CNT_W-1:0] NAME_LIM = CNT_W'(NAME_MAX);
  localparam logic [CNT_W-1:0] EXT_LIM  = CNT_W'(EXT_MAX);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUERY  = 8'h3F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DEL_TOP = 8'h7F;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // Plain name byte: 0x21 to 0x7F outside the reserved set
  function automatic logic is_plain_allowed(input logic [7:0] c);
    logic ok;
    ok = (c > CH_SPACE) && (c <= CH_DEL_TOP);
    case (c) inside
      CH_BSLASH, CH_SLASH, CH_LBRK, CH_RBRK, CH_LBRACE, CH_RBRACE,
      CH_COLON, CH_PIPE, CH_LT, CH_GT, CH_PLUS, CH_EQ,
      CH_COMMA, CH_SEMI, CH_DOT, CH_QUOTE, CH_QUERY, CH_STAR: ok = 1'b0;
      default: ;
    endcase
    is_plain_allowed = ok;
  endfunction

endpackage

`default_nettype wire

### hdl/dpn_if.sv
// Valid/ready channel interfaces for the DOS path name checker: byte input
// and verdict output. Depends on nothing.
`default_nettype none

interface dpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_code;
  logic       end_of_name;
  modport source (output valid, symbol_code, end_of_name, input ready);
  modport sink   (input valid, symbol_code, end_of_name, output ready);
endinterface

interface dpn_out_if;
  logic valid;
  logic ready;
  logic name_valid;
  modport source (output valid, name_valid, input ready);
  modport sink   (input valid, name_valid, output ready);
endinterface

`default_nettype wire

### hdl/dos_path_name_checker.sv
// DOS 8.3 path name checker, single module.
// Uses dpn_pkg and the channel interfaces in dpn_if.sv.
//
// Usage: the path string enters on in_chan one byte per transfer, with
// end_of_name set on its final byte. For each final byte one verdict leaves
// on out_chan: name_valid is 1 when the whole string is a valid 8.3 path
// (optional drive prefix, backslash-separated parts of at most 8 name and
// 3 extension bytes, wildcards only in the last part). Other bytes give no
// transfer on out_chan.
// Throughput: one byte per clock while no final byte is held (see Stall).
// Each byte is captured in an input register; when it fires, a single pass
// of flag and counter logic updates the per-string state and, on a final
// byte, loads the result register, which drives the verdict on out_chan.
// Stall: the result register holds while out_chan.ready is low; bytes that
// produce no verdict keep flowing, and a final byte waits in the input
// register until the result register is free, which then drops in ready.
// Reset (rst_n low, synchronous): state returns to the start of a string
// and both registers empty. After each final byte the state also returns to
// the start of a string.
`default_nettype none

module dos_path_name_checker
  import dpn_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  dpn_in_if.sink     in_chan,
  dpn_out_if.source  out_chan
);

  // Input register
  logic       in_valid_r;
  logic [7:0] sym_r;
  logic       last_r;

  // Per-string state
  logic             lead_r,  lead_nxt;
  logic [1:0]       pos_r,   pos_nxt;
  logic             first_r, first_nxt;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic             dot_r,   dot_nxt;
  logic             wild_r,  wild_nxt;
  logic             fail_r,  fail_nxt;

  // Result register
  logic out_valid_r;
  logic verdict_r, verdict_nxt;

  logic             fire;
  logic             in_ready;
  logic             fail_w;
  logic [CNT_W-1:0] limit;
  logic [CNT_W:0]   cnt_inc;

  assign fire     = in_valid_r && (!last_r || !out_valid_r || out_chan.ready);
  assign in_ready = !in_valid_r || fire;

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.name_valid = verdict_r;

  assign limit   = dot_r ? EXT_LIM : NAME_LIM;
  assign cnt_inc = {1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    lead_nxt    = lead_r;
    pos_nxt     = pos_r;
    first_nxt   = first_r;
    cnt_nxt     = cnt_r;
    dot_nxt     = dot_r;
    wild_nxt    = wild_r;
    fail_w      = fail_r;
    verdict_nxt = 1'b0;

    if (lead_r && (sym_r == CH_SPACE)) begin
      // skip leading space; an all-space string is invalid
      verdict_nxt = 1'b0;
    end else begin
      lead_nxt = 1'b0;
      if (sym_r == CH_BSLASH) begin
        if (wild_r) fail_w = 1'b1;
        cnt_nxt  = '0;
        dot_nxt  = 1'b0;
        wild_nxt = 1'b0;
      end else if ((sym_r == CH_COLON) && (pos_r == 2'd1)) begin
        if (!first_r) fail_w = 1'b1;
        cnt_nxt  = '0;
        dot_nxt  = 1'b0;
        wild_nxt = 1'b0;
      end else if (sym_r == CH_DOT) begin
        if (dot_r) begin
          fail_w = 1'b1;
        end else begin
          dot_nxt = 1'b1;
          cnt_nxt = '0;
        end
      end else if ((sym_r == CH_STAR) || (sym_r == CH_QUERY) || is_plain_allowed(sym_r)) begin
        if ((sym_r == CH_STAR) || (sym_r == CH_QUERY)) wild_nxt = 1'b1;
        // count the byte, saturate at the current limit
        if (cnt_inc > {1'b0, limit}) begin
          fail_w  = 1'b1;
          cnt_nxt = limit;
        end else begin
          cnt_nxt = cnt_inc[CNT_W-1:0];
        end
      end else begin
        fail_w = 1'b1;
      end

      if (pos_r == 2'd0) first_nxt = is_letter(sym_r);
      if (pos_r < 2'd2) pos_nxt = pos_r + 2'd1;

      if ((sym_r == CH_BSLASH) || (sym_r == CH_COLON)) begin
        verdict_nxt = 1'b0;
      end else begin
        verdict_nxt = !fail_w;
      end
    end

    fail_nxt = fail_w;
    if (last_r) begin
      // back to the start of a string
      lead_nxt  = 1'b1;
      pos_nxt   = 2'd0;
      first_nxt = 1'b0;
      cnt_nxt   = '0;
      dot_nxt   = 1'b0;
      wild_nxt  = 1'b0;
      fail_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      sym_r  <= in_chan.symbol_code;
      last_r <= in_chan.end_of_name;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= 1'b1;
      pos_r   <= 2'd0;
      first_r <= 1'b0;
      cnt_r   <= '0;
      dot_r   <= 1'b0;
      wild_r  <= 1'b0;
      fail_r  <= 1'b0;
    end else if (fire) begin
      lead_r  <= lead_nxt;
      pos_r   <= pos_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
      dot_r   <= dot_nxt;
      wild_r  <= wild_nxt;
      fail_r  <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last_r) begin
      verdict_r <= verdict_nxt;
    end
  end

  // Never overwrite a verdict that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last_r) |-> (!out_valid_r || out_chan.ready))
    else $error("verdict overwritten before transfer");

  // A final byte leaves the state at the start of a string
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last_r) |=> (lead_r && (pos_r == 2'd0) && !fail_r && (cnt_r == '0)))
    else $error("state not cleared after final byte");

  // Part count stays within the name limit
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NAME_LIM)
    else $error("part count beyond limit");

  // A held input byte blocks new transfers
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !fire) |-> !in_ready)
    else $error("input taken while byte held");

endmodule

`default_nettype wire
